### rtl/onoe_pkg.sv
package onoe_pkg;

    // Transmit event codes; values 6 and 7 are ignored
    typedef enum logic [2:0] {
        OP_RTS_FAIL   = 3'd0,
        OP_DATA_FAIL  = 3'd1,
        OP_RTS_FINAL  = 3'd2,
        OP_DATA_FINAL = 3'd3,
        OP_DATA_OK    = 3'd4,
        OP_GET_RATE   = 3'd5
    } opcode_t;

    // APB register map, one 32-bit word per register
    localparam int APB_ADDR_WIDTH = 4;
    localparam logic [1:0] REG_UPDATE_PERIOD  = 2'd0;
    localparam logic [1:0] REG_CREDIT_PERCENT = 2'd1;
    localparam logic [1:0] REG_RAISE_CREDITS  = 2'd2;
    localparam logic [1:0] REG_RATE_COUNT     = 2'd3;

    // Register reset values
    localparam logic [31:0] UPDATE_PERIOD_RST  = 32'd1000;
    localparam logic [6:0]  CREDIT_PERCENT_RST = 7'd10;
    localparam logic [7:0]  RAISE_CREDITS_RST  = 8'd10;
    localparam logic [4:0]  RATE_COUNT_RST     = 5'd8;

    // Decision constants
    localparam int          ENOUGH_SAMPLES = 10;
    localparam int          PERCENT_SCALE  = 100;
    localparam logic [4:0]  RATE_TABLE_MAX = 5'd16;
    localparam logic [7:0]  SAT8_MAX       = 8'hFF;

    // Long retry thresholds for the answer backoff
    localparam logic [7:0]  BACKOFF_STEP1 = 8'd4;
    localparam logic [7:0]  BACKOFF_STEP2 = 8'd6;
    localparam logic [7:0]  BACKOFF_STEP3 = 8'd8;

    typedef struct packed {
        logic [31:0] update_period;
        logic [6:0]  credit_percent;
        logic [7:0]  raise_credits;
        logic [4:0]  rate_count;
    } cfg_t;

    typedef struct packed {
        logic [3:0] base_rate;
        logic [7:0] credit_count;
    } decision_t;

endpackage

### rtl/onoe_evt_if.sv
interface onoe_evt_if #(
    parameter int TIME_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            opcode;
    logic [TIME_WIDTH-1:0] now_time;

    modport source (output valid, output opcode, output now_time, input ready);
    modport sink   (input valid, input opcode, input now_time, output ready);
endinterface

### rtl/onoe_rsp_if.sv
interface onoe_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] rate_index;

    modport source (output valid, output rate_index, input ready);
    modport sink   (input valid, input rate_index, output ready);
endinterface

### rtl/onoe_rate_adaptation.sv
// Channel   Dir   Word fields            Handshake
// evt       in    opcode, now_time       valid/ready
// rsp       out   rate_index             valid/ready
// apb       cfg   paddr, pwdata, prdata  psel/penable, pready tied high
//
// One event word is accepted per cycle unless a rate request waits. Each word
// is registered, then all counter updates and the period decision run
// combinationally into the state and the result register. Only a rate request
// waits while the sink holds the result register; later words stall behind it.
// Reset is asynchronous, active low, and restores all counters, the rate and
// the register defaults at once.
module onoe_rate_adaptation #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    onoe_evt_if.sink                            evt,
    onoe_rsp_if.source                          rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [onoe_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int                     FW      = COUNT_WIDTH + 2;

    onoe_pkg::cfg_t      cfg;
    onoe_pkg::decision_t dec;

    // input stage
    logic                  s1_valid_reg;
    logic [2:0]            s1_op_reg;
    logic [TIME_WIDTH-1:0] s1_time_reg;

    // block state
    logic [7:0]             short_retries_reg;
    logic [7:0]             long_retries_reg;
    logic [COUNT_WIDTH-1:0] ok_count_reg;
    logic [COUNT_WIDTH-1:0] err_count_reg;
    logic [COUNT_WIDTH-1:0] retry_total_reg;
    logic [7:0]             credit_count_reg;
    logic [3:0]             base_rate_reg;
    logic [TIME_WIDTH-1:0]  next_update_time_reg;

    // result stage
    logic       out_valid_reg;
    logic [3:0] rate_index_reg;

    logic                   s1_is_get;
    logic                   out_free;
    logic                   s1_adv;
    logic                   period_due;
    logic [FW-1:0]          fold_sum;
    logic [COUNT_WIDTH-1:0] retry_fold;
    logic [3:0]             base_eff;
    logic [1:0]             back;
    logic [3:0]             rate_next;

    onoe_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    onoe_decide #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decide (
        .ok_count     (ok_count_reg),
        .err_count    (err_count_reg),
        .retry_total  (retry_total_reg),
        .credit_count (credit_count_reg),
        .base_rate    (base_rate_reg),
        .cfg          (cfg),
        .dec          (dec)
    );

    // flow control: only a rate request needs the result register
    assign s1_is_get  = s1_valid_reg && (s1_op_reg == onoe_pkg::OP_GET_RATE);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_adv     = s1_valid_reg && (!s1_is_get || out_free);
    assign evt.ready  = !s1_valid_reg || s1_adv;
    assign rsp.valid  = out_valid_reg;
    assign rsp.rate_index = rate_index_reg;

    assign period_due = s1_time_reg > next_update_time_reg;

    // fold frame retries into the period total, saturating
    assign fold_sum   = FW'(retry_total_reg) + FW'(short_retries_reg) + FW'(long_retries_reg);
    assign retry_fold = (|fold_sum[FW-1:COUNT_WIDTH]) ? CNT_MAX : fold_sum[COUNT_WIDTH-1:0];

    // answer: base rate backed off by long retries
    assign base_eff = period_due ? dec.base_rate : base_rate_reg;

    always_comb
    begin
        if (long_retries_reg < onoe_pkg::BACKOFF_STEP1)
            back = 2'd0;
        else if (long_retries_reg < onoe_pkg::BACKOFF_STEP2)
            back = 2'd1;
        else if (long_retries_reg < onoe_pkg::BACKOFF_STEP3)
            back = 2'd2;
        else
            back = 2'd3;
    end

    assign rate_next = (base_eff >= {2'd0, back}) ? base_eff - {2'd0, back} : 4'd0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (evt.ready)
            s1_valid_reg <= evt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            s1_op_reg   <= evt.opcode;
            s1_time_reg <= evt.now_time;
        end
    end

    // counter and rate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_retries_reg    <= 8'd0;
            long_retries_reg     <= 8'd0;
            ok_count_reg         <= '0;
            err_count_reg        <= '0;
            retry_total_reg      <= '0;
            credit_count_reg     <= 8'd0;
            base_rate_reg        <= 4'd0;
            next_update_time_reg <= TIME_WIDTH'(onoe_pkg::UPDATE_PERIOD_RST);
        end
        else if (s1_adv)
        begin
            case (s1_op_reg) inside
                onoe_pkg::OP_RTS_FAIL:
                begin
                    if (short_retries_reg != onoe_pkg::SAT8_MAX)
                        short_retries_reg <= short_retries_reg + 8'd1;
                end
                onoe_pkg::OP_DATA_FAIL:
                begin
                    if (long_retries_reg != onoe_pkg::SAT8_MAX)
                        long_retries_reg <= long_retries_reg + 8'd1;
                end
                onoe_pkg::OP_RTS_FINAL, onoe_pkg::OP_DATA_FINAL:
                begin
                    retry_total_reg   <= retry_fold;
                    short_retries_reg <= 8'd0;
                    long_retries_reg  <= 8'd0;
                    if (err_count_reg != CNT_MAX)
                        err_count_reg <= err_count_reg + COUNT_WIDTH'(1);
                end
                onoe_pkg::OP_DATA_OK:
                begin
                    retry_total_reg   <= retry_fold;
                    short_retries_reg <= 8'd0;
                    long_retries_reg  <= 8'd0;
                    if (ok_count_reg != CNT_MAX)
                        ok_count_reg <= ok_count_reg + COUNT_WIDTH'(1);
                end
                onoe_pkg::OP_GET_RATE:
                begin
                    if (period_due)
                    begin
                        base_rate_reg        <= dec.base_rate;
                        credit_count_reg     <= dec.credit_count;
                        ok_count_reg         <= '0;
                        err_count_reg        <= '0;
                        retry_total_reg      <= '0;
                        next_update_time_reg <= s1_time_reg +
                                                TIME_WIDTH'(cfg.update_period);
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_adv && s1_is_get;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_adv && s1_is_get)
            rate_index_reg <= rate_next;
    end

endmodule

### rtl/onoe_apb_regs.sv
module onoe_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [onoe_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output onoe_pkg::cfg_t                      cfg
);

    onoe_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[onoe_pkg::APB_ADDR_WIDTH-1:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_period  <= onoe_pkg::UPDATE_PERIOD_RST;
            cfg_reg.credit_percent <= onoe_pkg::CREDIT_PERCENT_RST;
            cfg_reg.raise_credits  <= onoe_pkg::RAISE_CREDITS_RST;
            cfg_reg.rate_count     <= onoe_pkg::RATE_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                onoe_pkg::REG_UPDATE_PERIOD:  cfg_reg.update_period  <= pwdata;
                onoe_pkg::REG_CREDIT_PERCENT: cfg_reg.credit_percent <= pwdata[6:0];
                onoe_pkg::REG_RAISE_CREDITS:  cfg_reg.raise_credits  <= pwdata[7:0];
                onoe_pkg::REG_RATE_COUNT:     cfg_reg.rate_count     <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            onoe_pkg::REG_UPDATE_PERIOD:  prdata = cfg_reg.update_period;
            onoe_pkg::REG_CREDIT_PERCENT: prdata = {25'd0, cfg_reg.credit_percent};
            onoe_pkg::REG_RAISE_CREDITS:  prdata = {24'd0, cfg_reg.raise_credits};
            onoe_pkg::REG_RATE_COUNT:     prdata = {27'd0, cfg_reg.rate_count};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

### rtl/onoe_decide.sv
module onoe_decide #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0] ok_count,
    input  logic [COUNT_WIDTH-1:0] err_count,
    input  logic [COUNT_WIDTH-1:0] retry_total,
    input  logic [7:0]             credit_count,
    input  logic [3:0]             base_rate,
    input  onoe_pkg::cfg_t         cfg,
    output onoe_pkg::decision_t    dec
);

    localparam int PW = COUNT_WIDTH + 8;

    logic [COUNT_WIDTH:0] sample_sum;
    logic [COUNT_WIDTH:0] retry_inc;
    logic [PW-1:0]        retry_scaled;
    logic [PW-1:0]        ok_scaled;
    logic                 enough;
    logic                 few_retries;
    logic                 go_up;
    logic                 go_down;
    logic [4:0]           len;
    logic [7:0]           credit_inc;
    logic [3:0]           raised;
    logic [3:0]           nrate;
    logic [7:0]           ncredit;

    // sample count and the retry ratio test:
    // retry < ok*pct/100  <=>  100*(retry+1) <= ok*pct
    assign sample_sum   = {1'b0, ok_count} + {1'b0, err_count};
    assign enough       = sample_sum >= (COUNT_WIDTH+1)'(onoe_pkg::ENOUGH_SAMPLES);
    assign retry_inc    = {1'b0, retry_total} + (COUNT_WIDTH+1)'(1);
    assign retry_scaled = PW'(retry_inc) * PW'(onoe_pkg::PERCENT_SCALE);
    assign ok_scaled    = PW'(ok_count) * PW'(cfg.credit_percent);
    assign few_retries  = retry_scaled <= ok_scaled;

    assign go_up   = enough && (err_count == '0) && few_retries;
    assign go_down = ((err_count != '0) && (ok_count == '0)) ||
                     (enough && (ok_count < retry_total));

    // usable table length, clamped to 1..16
    always_comb
    begin
        if (cfg.rate_count == 5'd0)
            len = 5'd1;
        else if (cfg.rate_count > onoe_pkg::RATE_TABLE_MAX)
            len = onoe_pkg::RATE_TABLE_MAX;
        else
            len = cfg.rate_count;
    end

    assign credit_inc = (credit_count == onoe_pkg::SAT8_MAX) ? credit_count
                                                             : credit_count + 8'd1;
    assign raised     = (({1'b0, base_rate} + 5'd2) < len) ? base_rate + 4'd1
                                                           : 4'(len - 5'd1);

    // step decision
    always_comb
    begin
        nrate   = base_rate;
        ncredit = credit_count;
        if (go_up)
        begin
            ncredit = credit_inc;
            if (credit_inc >= cfg.raise_credits)
            begin
                nrate   = raised;
                ncredit = 8'd0;
            end
        end
        else if (go_down)
        begin
            nrate   = (base_rate == 4'd0) ? 4'd0 : base_rate - 4'd1;
            ncredit = 8'd0;
        end
        else if (enough && (credit_count != 8'd0))
        begin
            ncredit = credit_count - 8'd1;
        end
        // any rate change restarts the credit run
        if (nrate != base_rate)
            ncredit = 8'd0;
    end

    assign dec.base_rate    = nrate;
    assign dec.credit_count = ncredit;

endmodule

### rtl/onoe_checker.sv
module onoe_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                evt_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [3:0]                          rsp_rate_index,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [onoe_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input logic [31:0]                         pwdata,
    input logic [31:0]                         prdata
);

    // a held result word stays valid
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    // a held result word keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_rate_index))
        else $error("result word changed while stalled");

    // event input only stalls behind a blocked result word
    a_evt_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !evt_ready |-> rsp_valid && !rsp_ready)
        else $error("event input stalled without output backpressure");

    // a raise_credits write reads back on a read right after it
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite &&
        (paddr[onoe_pkg::APB_ADDR_WIDTH-1:2] == onoe_pkg::REG_RAISE_CREDITS)
        |=> !(psel && !pwrite &&
              (paddr[onoe_pkg::APB_ADDR_WIDTH-1:2] == onoe_pkg::REG_RAISE_CREDITS)) ||
            (prdata == {24'd0, $past(pwdata[7:0])}))
        else $error("raise_credits readback mismatch");

endmodule

bind onoe_rate_adaptation onoe_checker u_onoe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt_ready      (evt.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_rate_index (rsp.rate_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
);

### verif/tb_onoe_rate_adaptation.sv
`timescale 1ns / 100ps

module tb_onoe_rate_adaptation;

    localparam int          TIME_W        = 32;
    localparam int          CNT_W         = 16;
    localparam int          CLK_PERIOD    = 12;
    localparam int          RESET_CYCLES  = 12;
    localparam int          RAND_WORDS    = 1200;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SAT_WORDS     = 260;
    localparam longint      CYCLE_LIMIT   = 2_000_000;
    localparam logic [31:0] CNT_TOP       = (32'd1 << CNT_W) - 32'd1;

    // Opcodes the block ignores
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // One row of the directed table; pin marks an expected rate typed in by hand
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] at;
        logic [7:0]  reps;
        logic        pin;
        logic [3:0]  rate;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [onoe_pkg::APB_ADDR_WIDTH-1:0] paddr;
    logic [31:0]                         pwdata;
    logic [31:0]                         prdata;
    logic                                pready;

    onoe_evt_if #(.TIME_WIDTH(TIME_W)) evt_bus ();
    onoe_rsp_if                        rsp_bus ();

    onoe_rate_adaptation #(
        .TIME_WIDTH  (TIME_W),
        .COUNT_WIDTH (CNT_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the registers
    logic [31:0] cf_period = onoe_pkg::UPDATE_PERIOD_RST;
    logic [6:0]  cf_pct    = onoe_pkg::CREDIT_PERCENT_RST;
    logic [7:0]  cf_raise  = onoe_pkg::RAISE_CREDITS_RST;
    logic [4:0]  cf_rates  = onoe_pkg::RATE_COUNT_RST;

    // Predictor copy of the rate state
    logic [7:0]       rc_short  = '0;
    logic [7:0]       rc_long   = '0;
    logic [CNT_W-1:0] rc_ok     = '0;
    logic [CNT_W-1:0] rc_err    = '0;
    logic [CNT_W-1:0] rc_retry  = '0;
    logic [7:0]       rc_credit = '0;
    logic [3:0]       rc_base   = '0;
    logic [31:0]      rc_next   = onoe_pkg::UPDATE_PERIOD_RST;

    logic [3:0]  rate_expect_q [$];
    logic [31:0] now_t       = '0;
    longint      cycle_count = 0;
    int          mismatches  = 0;
    int          words_sent  = 0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    rx_mode_t    rx_mode     = RX_FREE;
    logic [3:0]  seen_want;

    stim_row_t stim_rows [12] = '{
        '{onoe_pkg::OP_GET_RATE,   32'd0,    8'd1,  1'b1, 4'd0},
        '{OP_RSVD6,                32'd0,    8'd1,  1'b0, 4'd0},
        '{OP_RSVD7,                32'd0,    8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_DATA_OK,    32'd0,    8'd10, 1'b0, 4'd0},
        '{onoe_pkg::OP_GET_RATE,   32'd2000, 8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_DATA_FAIL,  32'd2000, 8'd4,  1'b0, 4'd0},
        '{onoe_pkg::OP_GET_RATE,   32'd2000, 8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_RTS_FAIL,   32'd2000, 8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_RTS_FINAL,  32'd2000, 8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_GET_RATE,   32'd2001, 8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_DATA_FINAL, 32'd2001, 8'd1,  1'b0, 4'd0},
        '{onoe_pkg::OP_GET_RATE,   32'd2005, 8'd1,  1'b0, 4'd0}
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] top);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, top}) ? top : s[31:0];
    endfunction

    // Time moves forward and sticks at its maximum
    function automatic logic [31:0] later(input logic [31:0] t, input int step);
        logic [32:0] s;
        s = {1'b0, t} + 33'(step);
        return s[32] ? '1 : s[31:0];
    endfunction

    // Apply one accepted word to the predicted state; a rate request queues its answer
    task automatic track_word(input logic [2:0] op, input bit pin, input logic [3:0] pin_rate);
        int         len;
        int         dir;
        int         nrate;
        int         back;
        bit         enough;
        logic [3:0] rate_out;
        if (op == onoe_pkg::OP_RTS_FINAL || op == onoe_pkg::OP_DATA_FINAL ||
            op == onoe_pkg::OP_DATA_OK)
        begin
            rc_retry = CNT_W'(sat_add(32'(rc_retry), 32'(rc_short) + 32'(rc_long), CNT_TOP));
            rc_short = '0;
            rc_long  = '0;
        end
        case (op)
            onoe_pkg::OP_RTS_FAIL:
                rc_short = 8'(sat_add(32'(rc_short), 32'd1, 32'(onoe_pkg::SAT8_MAX)));
            onoe_pkg::OP_DATA_FAIL:
                rc_long  = 8'(sat_add(32'(rc_long), 32'd1, 32'(onoe_pkg::SAT8_MAX)));
            onoe_pkg::OP_RTS_FINAL, onoe_pkg::OP_DATA_FINAL:
                rc_err = CNT_W'(sat_add(32'(rc_err), 32'd1, CNT_TOP));
            onoe_pkg::OP_DATA_OK:
                rc_ok  = CNT_W'(sat_add(32'(rc_ok), 32'd1, CNT_TOP));
            onoe_pkg::OP_GET_RATE:
            begin
                // periodic decision, plain unsigned compare against the wrapped deadline
                if (now_t > rc_next)
                begin
                    rc_next = now_t + cf_period;
                    len = int'(cf_rates);
                    if (len == 0)
                        len = 1;
                    if (len > int'(onoe_pkg::RATE_TABLE_MAX))
                        len = int'(onoe_pkg::RATE_TABLE_MAX);
                    enough = (int'(rc_ok) + int'(rc_err)) >= onoe_pkg::ENOUGH_SAMPLES;
                    dir = 0;
                    if (rc_err != 0 && rc_ok == 0)
                        dir = -1;
                    if (enough && rc_ok < rc_retry)
                        dir = -1;
                    if (enough && rc_err == 0 &&
                        int'(rc_retry) <
                        (int'(rc_ok) * int'(cf_pct)) / onoe_pkg::PERCENT_SCALE)
                        dir = 1;
                    nrate = int'(rc_base);
                    if (dir == 0)
                    begin
                        if (enough && rc_credit != 0)
                            rc_credit = rc_credit - 8'd1;
                    end
                    else if (dir < 0)
                    begin
                        if (nrate > 0)
                            nrate = nrate - 1;
                        rc_credit = '0;
                    end
                    else
                    begin
                        rc_credit = 8'(sat_add(32'(rc_credit), 32'd1,
                                               32'(onoe_pkg::SAT8_MAX)));
                        if (rc_credit >= cf_raise)
                        begin
                            // at the top the rate clamps to the last table entry
                            nrate = (nrate + 2 < len) ? nrate + 1 : len - 1;
                            rc_credit = '0;
                        end
                    end
                    if (nrate != int'(rc_base))
                    begin
                        rc_credit = '0;
                        rc_base = 4'(nrate);
                    end
                    rc_ok    = '0;
                    rc_err   = '0;
                    rc_retry = '0;
                end
                // back off by the long retries of the frame in flight
                if (rc_long < onoe_pkg::BACKOFF_STEP1)
                    back = 0;
                else if (rc_long < onoe_pkg::BACKOFF_STEP2)
                    back = 1;
                else if (rc_long < onoe_pkg::BACKOFF_STEP3)
                    back = 2;
                else
                    back = 3;
                rate_out = (int'(rc_base) >= back) ? 4'(int'(rc_base) - back) : 4'd0;
                rate_expect_q.push_back(pin ? pin_rate : rate_out);
            end
            default: ;
        endcase
    endtask

    // Offer one event word in bursts with random gaps; wait for the handshake
    task automatic send_word(input logic [2:0] op, input bit pin, input logic [3:0] pin_rate);
        if (gaps_on && burst_left == 0)
        begin
            @(negedge clk);
            evt_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        evt_bus.valid    <= 1'b1;
        evt_bus.opcode   <= op;
        evt_bus.now_time <= now_t;
        do @(posedge clk); while (!evt_bus.ready);
        if (op <= onoe_pkg::OP_GET_RATE)
            words_sent++;
        track_word(op, pin, pin_rate);
    endtask

    task automatic send_evt(input logic [2:0] op);
        send_word(op, 1'b0, 4'd0);
    endtask

    // One frame: retries, maybe a mid-frame rate request, usually a final, maybe a request
    task automatic send_frame(input int retry_pct, input int fail_pct, input int tstep);
        int n;
        n = 0;
        if ($urandom_range(0, 399) == 0)
            n = $urandom_range(256, 300);
        else if ($urandom_range(0, 99) < retry_pct)
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        repeat (n) send_evt($urandom_range(0, 1) ? onoe_pkg::OP_RTS_FAIL
                                                 : onoe_pkg::OP_DATA_FAIL);
        if ($urandom_range(0, 3) == 0)
            send_evt(onoe_pkg::OP_GET_RATE);
        // broken frame: no final
        if ($urandom_range(0, 14) == 0)
            return;
        if ($urandom_range(0, 99) < fail_pct)
            send_evt($urandom_range(0, 1) ? onoe_pkg::OP_RTS_FINAL
                                          : onoe_pkg::OP_DATA_FINAL);
        else
            send_evt(onoe_pkg::OP_DATA_OK);
        if ($urandom_range(0, 1))
        begin
            now_t = later(now_t, $urandom_range(0, tstep));
            send_evt(onoe_pkg::OP_GET_RATE);
        end
    endtask

    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
    endtask

    // Write a register, mirror it and read it back
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] want;
        apb_xfer(1'b1, idx, value, rd);
        want = value;
        case (idx)
            onoe_pkg::REG_UPDATE_PERIOD:  cf_period = value;
            onoe_pkg::REG_CREDIT_PERCENT:
            begin
                cf_pct = value[6:0];
                want = {25'd0, value[6:0]};
            end
            onoe_pkg::REG_RAISE_CREDITS:
            begin
                cf_raise = value[7:0];
                want = {24'd0, value[7:0]};
            end
            default:
            begin
                cf_rates = value[4:0];
                want = {27'd0, value[4:0]};
            end
        endcase
        apb_xfer(1'b0, idx, 32'd0, rd);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== want)
            report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rd, want));
    endtask

    // Stop offering, wait for every answer, then let trailing words clear the pipe
    task automatic drain_block();
        @(negedge clk);
        evt_bus.valid <= 1'b0;
        while (rate_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic configure(input logic [31:0] period, input logic [31:0] pct,
                             input logic [31:0] raise, input logic [31:0] rates);
        drain_block();
        cfg_write(onoe_pkg::REG_UPDATE_PERIOD, period);
        cfg_write(onoe_pkg::REG_CREDIT_PERCENT, pct);
        cfg_write(onoe_pkg::REG_RAISE_CREDITS, raise);
        cfg_write(onoe_pkg::REG_RATE_COUNT, rates);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (rate_expect_q.size() == 0)
                report_mismatch($sformatf("rate word %0d with none expected",
                                          rsp_bus.rate_index));
            else
            begin
                seen_want = rate_expect_q.pop_front();
                if (rsp_bus.rate_index !== seen_want)
                    report_mismatch($sformatf("rate_index %0d, expected %0d",
                                              rsp_bus.rate_index, seen_want));
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   rsp_bus.ready <= 1'b1;
                    RX_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_bus.ready <= ((mode_left % 4) != 0);
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [31:0] rd;
        logic [31:0] reset_regs [4];
        int          p_period;
        int          p_pct;
        int          p_raise;
        int          p_rates;
        int          p_retry;
        int          p_fail;
        int          p_tstep;
        int          phase_end;

        evt_bus.valid    = 1'b0;
        evt_bus.opcode   = onoe_pkg::OP_RTS_FAIL;
        evt_bus.now_time = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults after reset
        reset_regs[0] = onoe_pkg::UPDATE_PERIOD_RST;
        reset_regs[1] = {25'd0, onoe_pkg::CREDIT_PERCENT_RST};
        reset_regs[2] = {24'd0, onoe_pkg::RAISE_CREDITS_RST};
        reset_regs[3] = {27'd0, onoe_pkg::RATE_COUNT_RST};
        for (int i = 0; i < 4; i++)
        begin
            apb_xfer(1'b0, 2'(i), 32'd0, rd);
            if (rd !== reset_regs[i])
                report_mismatch($sformatf("register %0d resets to %h", i, rd));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;

        // directed table: fast decisions, a raise on every credit period
        configure(32'd1, 32'd100, 32'd0, 32'd16);
        foreach (stim_rows[r])
        begin
            now_t = stim_rows[r].at;
            repeat (stim_rows[r].reps)
                send_word(stim_rows[r].op, stim_rows[r].pin, stim_rows[r].rate);
        end

        // random phases, the first few at the register extremes
        for (int ph = 0; words_sent < RAND_WORDS; ph++)
        begin
            p_period = $urandom_range(1, 400);
            p_pct    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 100);
            p_raise  = $urandom_range(0, 6);
            p_rates  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(1, 16);
            p_retry  = $urandom_range(0, 60);
            p_fail   = $urandom_range(0, 40);
            p_tstep  = $urandom_range(1, 60);
            case (ph)
                0:
                begin
                    p_period = 1;
                    p_pct    = 0;
                    p_raise  = 1;
                    p_rates  = 1;
                    p_tstep  = 5;
                end
                1:
                begin
                    p_period = -1;
                    p_pct    = 127;
                    p_raise  = 255;
                    p_rates  = 31;
                end
                2:
                begin
                    // climb: clean frames, many per decision
                    p_period = 200;
                    p_pct    = 100;
                    p_raise  = 0;
                    p_rates  = 16;
                    p_retry  = 0;
                    p_fail   = 0;
                    p_tstep  = 30;
                end
                3:
                begin
                    // table shrinks below the current rate
                    p_period = 100;
                    p_pct    = 60;
                    p_raise  = 1;
                    p_rates  = 0;
                    p_retry  = 10;
                    p_fail   = 10;
                end
                4:       p_rates = 17;
                default: ;
            endcase
            configure(32'(p_period), 32'(p_pct), 32'(p_raise), 32'(p_rates));
            if (ph == 3)
                hold_req = 1'b1;
            phase_end = words_sent + $urandom_range(150, 250);
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    now_t = later(now_t, $urandom_range(0, p_tstep));
                    send_evt(3'($urandom_range(0, 7)));
                end
                else
                    send_frame(p_retry, p_fail, p_tstep);
            end
        end

        // failures step the rate down, then the retry counters hit their top, back to back
        configure(32'd1, 32'd100, 32'd1, 32'd16);
        gaps_on = 1'b0;
        now_t = later(now_t, 5000);
        repeat (18)
        begin
            send_evt(onoe_pkg::OP_DATA_FINAL);
            now_t = later(now_t, 2);
            send_evt(onoe_pkg::OP_GET_RATE);
        end
        repeat (SAT_WORDS) send_evt(onoe_pkg::OP_RTS_FAIL);
        repeat (SAT_WORDS) send_evt(onoe_pkg::OP_DATA_FAIL);
        now_t = later(now_t, 2);
        send_evt(onoe_pkg::OP_GET_RATE);
        send_evt(onoe_pkg::OP_DATA_OK);
        now_t = later(now_t, 2);
        send_evt(onoe_pkg::OP_GET_RATE);
        gaps_on = 1'b1;

        // time near the top: deadlines wrap, then time sticks at its maximum
        configure(32'($urandom_range(256, 4096)), 32'd50, 32'd1, 32'd16);
        now_t = 32'hFFFF_F000 + 32'($urandom_range(0, 255));
        phase_end = words_sent + 200;
        while (words_sent < phase_end)
            send_frame(20, 15, 200);

        drain_block();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
